// ----- rtl/fvn_pkg.sv -----
// ============================================================================
// fvn_pkg
// Shared types and constants for the fractal value noise block: field widths,
// hash constants, register map and the configuration register group.
// ============================================================================
package fvn_pkg;

  localparam int COORD_IN_W = 48;
  localparam int NOISE_W    = 32;
  localparam int SUM_W      = 40;
  localparam int CFG_W      = 24;
  localparam int CNT_W      = 5;
  localparam int AMP_W      = 32;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  // Integer hash constants, all arithmetic modulo 2^32.
  localparam logic [31:0] HASH_MUL_X = 32'd157;
  localparam logic [31:0] HASH_MUL_Y = 32'd2633;
  localparam int          HASH_SHL   = 13;
  localparam logic [31:0] HASH_MUL_Q = 32'd15731;
  localparam logic [31:0] HASH_ADD_Q = 32'd789221;
  localparam logic [31:0] HASH_ADD_M = 32'd1376312579;
  localparam logic [31:0] CORNER_ONE = 32'h4000_0000;

  localparam logic signed [SUM_W-1:0] SUM_HI = 40'sd2147483647;
  localparam logic signed [SUM_W-1:0] SUM_LO = -40'sd2147483648;
  localparam logic [NOISE_W-1:0]      NOISE_HI = 32'h7fff_ffff;
  localparam logic [NOISE_W-1:0]      NOISE_LO = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_OCT_CNT   = 2'd0,
    REG_BASE_FREQ = 2'd1,
    REG_LACUN     = 2'd2,
    REG_PERSIST   = 2'd3
  } reg_idx_t;

  localparam logic [CNT_W-1:0] RST_OCT_CNT   = 5'd6;
  localparam logic [CFG_W-1:0] RST_BASE_FREQ = 24'd65536;
  localparam logic [CFG_W-1:0] RST_LACUN     = 24'd131072;
  localparam logic [CFG_W-1:0] RST_PERSIST   = 24'd32768;

  typedef struct packed {
    logic [CNT_W-1:0] oct_cnt;
    logic [CFG_W-1:0] base_freq;
    logic [CFG_W-1:0] lacun;
    logic [CFG_W-1:0] persist;
  } cfg_t;

endpackage

// ----- rtl/fvn_if.sv -----
// ============================================================================
// fvn_in_if / fvn_out_if
// Valid/ready channels for sample points and noise results.
// ============================================================================
interface fvn_in_if import fvn_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_IN_W-1:0] coord_x;
  logic signed [COORD_IN_W-1:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink (input valid, input coord_x, input coord_y, output ready);
endinterface

interface fvn_out_if import fvn_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise_value;
  logic                      saturated;

  modport source (output valid, output noise_value, output saturated, input ready);
  modport sink (input valid, input noise_value, input saturated, output ready);
endinterface

// ----- rtl/fvn_scale.sv -----
// ============================================================================
// fvn_scale
// Two-stage coordinate scaler: floor(c * m / 2^F) modulo 2^(32+F), with the
// signed coordinate split into a 32-bit low part and a signed high part.
// ============================================================================
module fvn_scale import fvn_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [32+FRAC_BITS-1:0] coord_i,
  input  logic [CFG_W-1:0]        mult_i,
  output logic [32+FRAC_BITS-1:0] coord_o
);

  localparam int CW  = 32 + FRAC_BITS;
  localparam int LPW = 32 + CFG_W;
  localparam int HPW = FRAC_BITS + CFG_W + 1;
  localparam int PW  = 32 + HPW;

  logic        [LPW-1:0] plo_r;
  logic signed [HPW-1:0] phi_r;
  logic        [CW-1:0]  coord_r;
  logic        [PW-1:0]  full;

  assign full = {phi_r, 32'd0} + PW'(plo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r   <= LPW'(coord_i[31:0]) * LPW'(mult_i);
      phi_r   <= $signed(coord_i[CW-1:32]) * $signed({1'b0, mult_i});
      coord_r <= full[FRAC_BITS +: CW];
    end
  end

  assign coord_o = coord_r;

endmodule

// ----- rtl/fvn_hash.sv -----
// ============================================================================
// fvn_hash
// Four-stage lattice corner hash. Returns 1 - (m mod 2^31)/2^30 in units of 2^-30.
// ============================================================================
module fvn_hash import fvn_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        x_i,
  input  logic [31:0]        y_i,
  output logic signed [31:0] corner_o
);

  logic [31:0] n0;
  logic [31:0] n1;
  logic [31:0] m;
  logic [31:0] n1_r;
  logic [31:0] n2_r;
  logic [31:0] n3_r;
  logic [31:0] nn_r;
  logic [31:0] q_r;
  logic [31:0] corner_r;

  assign n0 = x_i * HASH_MUL_X + y_i * HASH_MUL_Y;
  assign n1 = (n0 << HASH_SHL) ^ n0;
  assign m  = n3_r * q_r + HASH_ADD_M;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r     <= n1;
      nn_r     <= n1_r * n1_r;
      n2_r     <= n1_r;
      q_r      <= nn_r * HASH_MUL_Q + HASH_ADD_Q;
      n3_r     <= n2_r;
      corner_r <= CORNER_ONE - {1'b0, m[30:0]};
    end
  end

  assign corner_o = $signed(corner_r);

endmodule

// ----- rtl/fvn_cell.sv -----
// ============================================================================
// fvn_cell
// One octave of the noise chain. Hashes the four corners, eases the
// fractions, blends, weights by the amplitude and adds into the running sum,
// while preparing the next octave's coordinates and amplitude. Ten stages.
// ============================================================================
module fvn_cell import fvn_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int OCT_IDX   = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  cfg_t                    cfg,
  input  logic                    valid_i,
  input  logic [32+FRAC_BITS-1:0] cx_i,
  input  logic [32+FRAC_BITS-1:0] cy_i,
  input  logic [AMP_W-1:0]        amp_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output logic                    valid_o,
  output logic [32+FRAC_BITS-1:0] cx_o,
  output logic [32+FRAC_BITS-1:0] cy_o,
  output logic [AMP_W-1:0]        amp_o,
  output logic signed [SUM_W-1:0] sum_o
);

  localparam int F   = FRAC_BITS;
  localparam int CW  = 32 + F;
  localparam int LAT = 10;
  localparam int PW  = 36 + F;
  localparam int APW = AMP_W / 2 + CFG_W;
  localparam int AFW = AMP_W + CFG_W;
  localparam logic [5:0]   IDX    = 6'(OCT_IDX);
  localparam logic [F+1:0] KTHREE = (F+2)'(3) << F;

  logic [31:0] x0, x1, y0, y1;
  logic signed [31:0] c00, c10, c01, c11;

  assign x0 = cx_i[F +: 32];
  assign y0 = cy_i[F +: 32];
  assign x1 = x0 + 32'd1;
  assign y1 = y0 + 32'd1;

  fvn_hash u_h00 (.clk(clk), .en(en), .x_i(x0), .y_i(y0), .corner_o(c00));
  fvn_hash u_h10 (.clk(clk), .en(en), .x_i(x1), .y_i(y0), .corner_o(c10));
  fvn_hash u_h01 (.clk(clk), .en(en), .x_i(x0), .y_i(y1), .corner_o(c01));
  fvn_hash u_h11 (.clk(clk), .en(en), .x_i(x1), .y_i(y1), .corner_o(c11));

  // Next octave's coordinates come out of the scalers after two stages.
  logic [CW-1:0] cxn, cyn;

  fvn_scale #(.FRAC_BITS(F)) u_scx (.clk(clk), .en(en), .coord_i(cx_i),
                                    .mult_i(cfg.lacun), .coord_o(cxn));
  fvn_scale #(.FRAC_BITS(F)) u_scy (.clk(clk), .en(en), .coord_i(cy_i),
                                    .mult_i(cfg.lacun), .coord_o(cyn));

  // Ease curve registers.
  logic [F-1:0]    s1_tx_r, s1_ty_r;
  logic [2*F-1:0]  s1_ttx_r, s1_tty_r;
  logic [2*F+1:0]  s2_skx_r, s2_sky_r;
  logic [F+1:0]    s3_sx_r, s3_sy_r, s4_sx_r, s4_sy_r, s5_sy_r, s6_sy_r;
  logic [F+1:0]    kx, ky;

  assign kx = KTHREE - {1'b0, s1_tx_r, 1'b0};
  assign ky = KTHREE - {1'b0, s1_ty_r, 1'b0};

  // Blend and weighting registers.
  logic signed [32:0]    dtop, dbot, dv;
  logic signed [PW-1:0]  s5_ptop_r, s5_pbot_r, s7_p_r;
  logic signed [31:0]    s5_atop_r, s5_abot_r, s6_top_r, s6_bot_r, s7_top_r, s8_val_r;
  logic signed [64:0]    s9_w_r;
  logic signed [34:0]    contrib;
  logic                  active;

  assign dtop    = {c10[31], c10} - {c00[31], c00};
  assign dbot    = {c11[31], c11} - {c01[31], c01};
  assign dv      = {s6_bot_r[31], s6_bot_r} - {s6_top_r[31], s6_top_r};
  assign contrib = s9_w_r[64:30];
  assign active  = IDX < {1'b0, cfg.oct_cnt};

  // Amplitude update, split into two 16-bit halves.
  logic [APW-1:0]  apl_r, aph_r;
  logic [AFW-1:0]  afull, ash;
  logic [AMP_W-1:0] s2_ampn_r;

  assign afull = {aph_r, 16'd0} + AFW'(apl_r);
  assign ash   = afull >> F;

  // Alignment lines.
  logic                    v_r      [1:LAT];
  logic signed [SUM_W-1:0] sum_d_r  [1:LAT-1];
  logic [AMP_W-1:0]        amp_d_r  [1:8];
  logic [CW-1:0]           nx_cx_r  [3:LAT];
  logic [CW-1:0]           nx_cy_r  [3:LAT];
  logic [AMP_W-1:0]        nx_amp_r [3:LAT];
  logic signed [SUM_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 1; j <= LAT; j++) v_r[j] <= 1'b0;
    end else if (en) begin
      v_r[1] <= valid_i;
      for (int j = 2; j <= LAT; j++) v_r[j] <= v_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tx_r   <= cx_i[F-1:0];
      s1_ty_r   <= cy_i[F-1:0];
      s1_ttx_r  <= (2*F)'(cx_i[F-1:0]) * (2*F)'(cx_i[F-1:0]);
      s1_tty_r  <= (2*F)'(cy_i[F-1:0]) * (2*F)'(cy_i[F-1:0]);
      s2_skx_r  <= (2*F+2)'(s1_ttx_r[2*F-1:F]) * (2*F+2)'(kx);
      s2_sky_r  <= (2*F+2)'(s1_tty_r[2*F-1:F]) * (2*F+2)'(ky);
      s3_sx_r   <= s2_skx_r[2*F+1:F];
      s3_sy_r   <= s2_sky_r[2*F+1:F];
      s4_sx_r   <= s3_sx_r;
      s4_sy_r   <= s3_sy_r;
      s5_sy_r   <= s4_sy_r;
      s6_sy_r   <= s5_sy_r;

      s5_ptop_r <= dtop * $signed({1'b0, s4_sx_r});
      s5_pbot_r <= dbot * $signed({1'b0, s4_sx_r});
      s5_atop_r <= c00;
      s5_abot_r <= c01;
      s6_top_r  <= s5_atop_r + $signed(s5_ptop_r[F +: 32]);
      s6_bot_r  <= s5_abot_r + $signed(s5_pbot_r[F +: 32]);
      s7_p_r    <= dv * $signed({1'b0, s6_sy_r});
      s7_top_r  <= s6_top_r;
      s8_val_r  <= s7_top_r + $signed(s7_p_r[F +: 32]);
      s9_w_r    <= s8_val_r * $signed({1'b0, amp_d_r[8]});
      sum_r     <= sum_d_r[LAT-1] + (active ? SUM_W'(contrib) : '0);

      apl_r     <= APW'(amp_i[AMP_W/2-1:0]) * APW'(cfg.persist);
      aph_r     <= APW'(amp_i[AMP_W-1:AMP_W/2]) * APW'(cfg.persist);
      s2_ampn_r <= (|ash[AFW-1:AMP_W]) ? '1 : ash[AMP_W-1:0];

      sum_d_r[1] <= sum_i;
      for (int j = 2; j <= LAT - 1; j++) sum_d_r[j] <= sum_d_r[j-1];
      amp_d_r[1] <= amp_i;
      for (int j = 2; j <= 8; j++) amp_d_r[j] <= amp_d_r[j-1];
      nx_cx_r[3]  <= cxn;
      nx_cy_r[3]  <= cyn;
      nx_amp_r[3] <= s2_ampn_r;
      for (int j = 4; j <= LAT; j++) begin
        nx_cx_r[j]  <= nx_cx_r[j-1];
        nx_cy_r[j]  <= nx_cy_r[j-1];
        nx_amp_r[j] <= nx_amp_r[j-1];
      end
    end
  end

  assign valid_o = v_r[LAT];
  assign cx_o    = nx_cx_r[LAT];
  assign cy_o    = nx_cy_r[LAT];
  assign amp_o   = nx_amp_r[LAT];
  assign sum_o   = sum_r;

endmodule

// ----- rtl/fractal_value_noise_2d.sv -----
// ============================================================================
// fractal_value_noise_2d
// Multi-octave 2-D value noise over a streaming point channel.
// ============================================================================
// A point arrives on in_ch as two signed Q32.16 coordinates and its noise
// value leaves on out_ch as a signed Q16.16 sum with a saturation flag, one
// result item for each input item, in order.
// The block is a front scaler followed by a chain of MAX_OCTAVES identical
// octave cells. Each cell holds one octave's hash, ease, blend and weighting
// stages and hands coordinates, amplitude and running sum to the next cell
// every cycle that the chain is not held. Octaves at or beyond the configured
// count pass the sum through. Throughput is one item per clock while the
// chain is not held. Each item passes through the base frequency scaler, the
// octave cells in order and the saturating output register.
// When the receiver stalls, the chain keeps moving until a finished result
// reaches the end while the output register is still full; only then does
// in_ch.ready drop and the whole chain hold.
// The four registers sit at APB byte offsets 0, 4, 8 and 12. The user must
// write them only while no item is in flight; the block does not enforce it.
// Synchronous reset empties the chain and output register, restores defaults.
// ============================================================================
module fractal_value_noise_2d import fvn_pkg::*; #(
  parameter int MAX_OCTAVES = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  fvn_in_if.sink            in_ch,
  fvn_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW = 32 + FRAC_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.oct_cnt   <= RST_OCT_CNT;
      cfg_r.base_freq <= RST_BASE_FREQ;
      cfg_r.lacun     <= RST_LACUN;
      cfg_r.persist   <= RST_PERSIST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OCT_CNT:   cfg_r.oct_cnt   <= pwdata[CNT_W-1:0];
        REG_BASE_FREQ: cfg_r.base_freq <= pwdata[CFG_W-1:0];
        REG_LACUN:     cfg_r.lacun     <= pwdata[CFG_W-1:0];
        REG_PERSIST:   cfg_r.persist   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OCT_CNT:   prdata = APB_DW'(cfg_r.oct_cnt);
      REG_BASE_FREQ: prdata = APB_DW'(cfg_r.base_freq);
      REG_LACUN:     prdata = APB_DW'(cfg_r.lacun);
      REG_PERSIST:   prdata = APB_DW'(cfg_r.persist);
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control. The chain advances as one; it holds only when a result
  // is ready at the end and the output register cannot take it.
  // --------------------------------------------------------------------------
  logic en;
  logic last_v;
  logic out_valid_r;

  assign en          = !(out_valid_r && !out_ch.ready && last_v);
  assign in_ch.ready = en;

  // --------------------------------------------------------------------------
  // Front: widen the input to Q32.F and scale by the base frequency.
  // --------------------------------------------------------------------------
  logic          fv_r [1:2];
  logic [CW-1:0] cx_w   [0:MAX_OCTAVES];
  logic [CW-1:0] cy_w   [0:MAX_OCTAVES];
  logic [AMP_W-1:0] amp_w [0:MAX_OCTAVES];
  logic signed [SUM_W-1:0] sum_w [0:MAX_OCTAVES];
  logic          v_w    [0:MAX_OCTAVES];
  logic [CW-1:0] in_cx, in_cy;

  assign in_cx = CW'($signed(in_ch.coord_x));
  assign in_cy = CW'($signed(in_ch.coord_y));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r[1] <= 1'b0;
      fv_r[2] <= 1'b0;
    end else if (en) begin
      fv_r[1] <= in_ch.valid;
      fv_r[2] <= fv_r[1];
    end
  end

  fvn_scale #(.FRAC_BITS(FRAC_BITS)) u_front_x (
    .clk(clk), .en(en), .coord_i(in_cx), .mult_i(cfg_r.base_freq), .coord_o(cx_w[0])
  );
  fvn_scale #(.FRAC_BITS(FRAC_BITS)) u_front_y (
    .clk(clk), .en(en), .coord_i(in_cy), .mult_i(cfg_r.base_freq), .coord_o(cy_w[0])
  );

  // The first octave starts with amplitude 1.0 and an empty sum.
  assign v_w[0]   = fv_r[2];
  assign amp_w[0] = AMP_W'(1) << FRAC_BITS;
  assign sum_w[0] = '0;

  // --------------------------------------------------------------------------
  // Octave chain.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    fvn_cell #(.FRAC_BITS(FRAC_BITS), .OCT_IDX(k)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg_r),
      .valid_i(v_w[k]), .cx_i(cx_w[k]), .cy_i(cy_w[k]),
      .amp_i(amp_w[k]), .sum_i(sum_w[k]),
      .valid_o(v_w[k+1]), .cx_o(cx_w[k+1]), .cy_o(cy_w[k+1]),
      .amp_o(amp_w[k+1]), .sum_o(sum_w[k+1])
    );
  end

  assign last_v = v_w[MAX_OCTAVES];

  // --------------------------------------------------------------------------
  // Saturation to Q16.16 and the output register.
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] fsum;
  logic [NOISE_W-1:0]      noise_nxt;
  logic                    sat_nxt;
  logic [NOISE_W-1:0]      noise_r;
  logic                    sat_r;

  assign fsum = sum_w[MAX_OCTAVES];

  always_comb begin
    if (fsum > SUM_HI) begin
      noise_nxt = NOISE_HI;
      sat_nxt   = 1'b1;
    end else if (fsum < SUM_LO) begin
      noise_nxt = NOISE_LO;
      sat_nxt   = 1'b1;
    end else begin
      noise_nxt = fsum[NOISE_W-1:0];
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_v && en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_v && en) begin
      noise_r <= noise_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.noise_value = $signed(noise_r);
  assign out_ch.saturated   = sat_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      (noise_r == NOISE_HI || noise_r == NOISE_LO))
    else $error("saturated result is not a range limit");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && !out_ch.ready))
    else $error("input held off while the output register is free");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("result presented right after reset");

endmodule

// ----- tb/sv/tb_fractal_value_noise_2d.sv -----
// ============================================================================
// tb_fractal_value_noise_2d
// Self-checking testbench for the fractal value noise block. Sample points are
// streamed under random idling on both channels, each noise value is predicted
// in the bench and compared field by field, and the configuration registers
// are swept through several settings on the APB port between phases.
// ============================================================================
module tb_fractal_value_noise_2d import fvn_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC     = 16;
  localparam int MAX_OCT  = 16;
  localparam int LATENCY  = 2 + 10 * MAX_OCT + 1;
  localparam int CYC_LIMIT = 2000000;

  typedef struct packed {
    logic signed [COORD_IN_W-1:0] cx;
    logic signed [COORD_IN_W-1:0] cy;
  } point_t;

  typedef struct packed {
    logic [NOISE_W-1:0] noise;
    logic               sat;
  } noise_res_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  fvn_in_if  in_ch ();
  fvn_out_if out_ch ();

  fractal_value_noise_2d i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the configuration registers used by the predictor.
  logic [CNT_W-1:0] oct_cnt_q;
  logic [CFG_W-1:0] base_freq_q, lacun_q, persist_q;

  point_t     pending_points[$];
  noise_res_t expected_noise[$];
  int         send_idle_pct, recv_idle_pct;
  int         mismatches, points_sent, results_seen;
  longint     cycle_cnt;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Scale a 48-bit coordinate by an unsigned Q8.16 multiplier, floor, wrap.
  function automatic logic [47:0] scale_coord(logic [47:0] c, logic [CFG_W-1:0] m);
    logic signed [79:0] prod;
    prod = $signed({{32{c[47]}}, c}) * $signed({56'd0, m});
    return prod[FRAC +: 48];
  endfunction

  function automatic longint corner_val(logic [31:0] x, logic [31:0] y);
    logic [31:0] n;
    n = x * 32'd157 + y * 32'd2633;
    n = (n << 13) ^ n;
    n = n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312579;
    return longint'(32'h4000_0000) - longint'({1'b0, n[30:0]});
  endfunction

  function automatic longint ease_frac(logic [15:0] t);
    longint t2, k;
    t2 = (longint'(t) * longint'(t)) >>> FRAC;
    k  = (longint'(3) << FRAC) - 2 * longint'(t);
    return (t2 * k) >>> FRAC;
  endfunction

  function automatic longint blend(longint a, longint b, longint s);
    return a + (((b - a) * s) >>> FRAC);
  endfunction

  function automatic noise_res_t predict_noise(point_t p);
    logic [47:0] cx, cy;
    logic [31:0] x0, y0;
    longint amp, sum, sx, sy, top, bot, oct;
    int cnt;
    noise_res_t r;
    cx  = scale_coord(p.cx, base_freq_q);
    cy  = scale_coord(p.cy, base_freq_q);
    amp = longint'(1) << FRAC;
    sum = 0;
    cnt = (oct_cnt_q > MAX_OCT) ? MAX_OCT : oct_cnt_q;
    for (int i = 0; i < cnt; i++) begin
      x0  = cx[47:16];
      y0  = cy[47:16];
      sx  = ease_frac(cx[15:0]);
      sy  = ease_frac(cy[15:0]);
      top = blend(corner_val(x0, y0), corner_val(x0 + 1, y0), sx);
      bot = blend(corner_val(x0, y0 + 1), corner_val(x0 + 1, y0 + 1), sx);
      oct = blend(top, bot, sy);
      // The product oct*amp fits in 64 bits: |oct| <= 2^31, amp < 2^32.
      sum += (oct * amp) >>> 30;
      cx  = scale_coord(cx, lacun_q);
      cy  = scale_coord(cy, lacun_q);
      amp = (amp * longint'(persist_q)) >>> FRAC;
      if (amp > 64'hFFFF_FFFF) amp = 64'hFFFF_FFFF;
    end
    r.sat = 1'b1;
    if (sum > 64'sd2147483647) r.noise = NOISE_HI;
    else if (sum < -64'sd2147483648) r.noise = NOISE_LO;
    else begin
      r.noise = sum[31:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  // Track acceptance at the rising edge so the driver knows when to advance.
  logic in_taken;
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Driver: presents queued points at the falling edge, idling at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.coord_x <= '0;
      in_ch.coord_y <= '0;
      out_ch.ready  <= 1'b0;
    end else begin
      if (!in_ch.valid || in_taken) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.coord_x <= pending_points[0].cx;
          in_ch.coord_y <= pending_points[0].cy;
          expected_noise.push_back(predict_noise(pending_points.pop_front()));
          points_sent++;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    noise_res_t want;
    cycle_cnt++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_noise.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: noise=%h sat=%b",
                                       out_ch.noise_value, out_ch.saturated);
      end else begin
        want = expected_noise.pop_front();
        if (out_ch.noise_value !== want.noise || out_ch.saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise mismatch: expected %h/%b, got %h/%b", want.noise,
                     want.sat, out_ch.noise_value, out_ch.saturated);
        end
      end
    end
    if (cycle_cnt > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[fractal_value_noise_2d] ERROR");
      $finish;
    end
  end

  // APB write: setup then access; pready is always high.
  task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << 2;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_OCT_CNT:   oct_cnt_q   = val[CNT_W-1:0];
      REG_BASE_FREQ: base_freq_q = val[CFG_W-1:0];
      REG_LACUN:     lacun_q     = val[CFG_W-1:0];
      default:       persist_q   = val[CFG_W-1:0];
    endcase
  endtask

  task automatic set_config(int oct, int freq, int lac, int per);
    write_reg(REG_OCT_CNT, oct);
    write_reg(REG_BASE_FREQ, freq);
    write_reg(REG_LACUN, lac);
    write_reg(REG_PERSIST, per);
  endtask

  // Waits until the chain has drained; every item yields a result.
  task automatic drain();
    while (pending_points.size() > 0 || expected_noise.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()} >> 16);
  endfunction

  // Mostly small coordinates, sometimes full range.
  task automatic queue_random(int n);
    point_t p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        p.cx = rand48();
        p.cy = rand48();
      end else begin
        p.cx = 48'($signed($urandom_range(2000000)) - 1000000) * 48'sd64;
        p.cy = 48'($signed($urandom_range(2000000)) - 1000000) * 48'sd64;
        p.cx[5:0] = 6'($urandom());
        p.cy[5:0] = 6'($urandom());
      end
      pending_points.push_back(p);
    end
  endtask

  task automatic queue_point(logic [47:0] x, logic [47:0] y);
    point_t p;
    p.cx = x;
    p.cy = y;
    pending_points.push_back(p);
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 25; recv_idle_pct = 65;
    mismatches = 0; points_sent = 0; results_seen = 0; cycle_cnt = 0;
    oct_cnt_q = RST_OCT_CNT;    base_freq_q = RST_BASE_FREQ;
    lacun_q   = RST_LACUN;      persist_q   = RST_PERSIST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed points under reset defaults: extremes, zero, cell borders.
    queue_point(48'h0, 48'h0);
    queue_point(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
    queue_point(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
    queue_point(48'hFFFF_FFFF_FFFF, 48'h0000_0000_FFFF);
    queue_point(48'h0000_0001_0000, 48'hFFFF_FFFF_0000);
    queue_point(48'h0000_0000_8000, 48'h0000_0000_7FFF);
    queue_point(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
    drain();

    // Saturating sum: many octaves, large amplitude growth.
    set_config(16, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    queue_point(48'h0000_0003_1234, 48'hFFFF_FFF1_8000);
    queue_point(48'h1234_5678_9ABC, 48'hFEDC_BA98_7654);
    queue_point(48'h0, 48'h0000_0000_0001);
    drain();
    // Zero octaves and octave counts beyond the limit.
    set_config(0, 24'h010000, 24'h020000, 24'h008000);
    queue_point(48'h0000_0002_4000, 48'h0000_0005_C000);
    drain();
    set_config(31, 24'h0, 24'h0, 24'h0);
    queue_point(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
    drain();
    set_config(20, 24'h003000, 24'h01C000, 24'h00C000);
    queue_point(48'h0000_0007_7777, 48'hFFFF_FFF9_9999);
    drain();

    set_config(6, 24'h010000, 24'h020000, 24'h008000);
    queue_random(130);
    drain();
    send_idle_pct = 65; recv_idle_pct = 25;
    set_config(1, 24'h000100, 24'h0FFFFF, 24'h020000);
    queue_random(130);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_config(16, 24'h018000, 24'h01A000, 24'h012000);
    queue_random(140);
    drain();

    repeat (LATENCY + 20) @(posedge clk);
    $display("sent %0d sample points over eight register settings, checked %0d results",
             points_sent, results_seen);
    if (mismatches == 0 && expected_noise.size() == 0) begin
      $display("[fractal_value_noise_2d] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_noise.size());
      $display("[fractal_value_noise_2d] ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/fvn_pkg.sv
rtl/fvn_if.sv
rtl/fvn_scale.sv
rtl/fvn_hash.sv
rtl/fvn_cell.sv
rtl/fractal_value_noise_2d.sv
tb/sv/tb_fractal_value_noise_2d.sv
